// File: rtl/core/lspc_pkg.sv
package lspc_pkg;

	localparam int DEF_PIXELS_PER_LINE = 128;
	localparam int DEF_SAMPLE_BITS     = 12;
	localparam int QUEUE_DEPTH         = 2;

	localparam int INDEX_W = 7;
	localparam int VALUE_W = 8;
	localparam int CFG_W   = 8;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [CFG_W-1:0] RST_SAMPLES_PER_PIXEL = 8'd200;
	localparam logic [CFG_W-1:0] RST_DISPLAY_HEIGHT    = 8'd160;

	typedef enum logic {
		REG_SAMPLES_PER_PIXEL = 1'b0,
		REG_DISPLAY_HEIGHT    = 1'b1
	} reg_index_t;

endpackage

// File: rtl/core/lspc_sample_if.sv
interface lspc_sample_if import lspc_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] adc_sample;
	logic                   frame_start;

	modport source (output valid, output adc_sample, output frame_start, input ready);
	modport sink   (input valid, input adc_sample, input frame_start, output ready);
endinterface

// File: rtl/core/lspc_pixel_if.sv
interface lspc_pixel_if import lspc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] pixel_index;
	logic [VALUE_W-1:0] pixel_value;
	logic               last_pixel;

	modport source (output valid, output pixel_index, output pixel_value, output last_pixel,
		input ready);
	modport sink   (input valid, input pixel_index, input pixel_value, input last_pixel,
		output ready);
endinterface

// File: rtl/core/line_sensor_pixel_conditioner.sv
// Line-scan sensor pixel conditioner. Converter readings are taken one per
// clock into an accumulator while the queue has room; every samples_per_pixel
// readings (0 acts as 1) close a pixel, which is queued (two entries) for the
// back end. The back end averages with a serial divider, scales by
// display_height/(2^SAMPLE_BITS-1) clamped below display_height, and applies
// three-tap smoothing to all but the first and last pixels of the line. It
// takes a new pixel from the queue only when idle, after finishing the last one.
// Results lag by one pixel; the last pixel emits two transactions, the second
// with last_pixel set. frame_start restarts the line before its sample counts,
// dropping the partial pixel. Registers: samples_per_pixel at 0x0 (reset 200),
// display_height at 0x4 (reset 160); write them only while the block is idle.
module line_sensor_pixel_conditioner import lspc_pkg::*; #(
	parameter int PIXELS_PER_LINE = DEF_PIXELS_PER_LINE,
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	lspc_sample_if.sink       samples,
	lspc_pixel_if.source      pixels,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int SUM_W = SAMPLE_BITS + CFG_W;
	localparam int POS_W = $clog2(PIXELS_PER_LINE);
	localparam int JOB_W = SUM_W + CFG_W + POS_W + 1;

	logic [CFG_W-1:0] spp_q, height_q;
	reg_index_t       reg_sel;
	logic             cfg_write;

	logic             fq_valid, fq_ready, qb_valid, qb_ready;
	logic [JOB_W-1:0] fq_data, qb_data;

	assign reg_sel   = reg_index_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_comb begin
		case (reg_sel)
			REG_SAMPLES_PER_PIXEL: prdata = APB_DW'(spp_q);
			REG_DISPLAY_HEIGHT:    prdata = APB_DW'(height_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q    <= RST_SAMPLES_PER_PIXEL;
			height_q <= RST_DISPLAY_HEIGHT;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_SAMPLES_PER_PIXEL: spp_q    <= pwdata[CFG_W-1:0];
				REG_DISPLAY_HEIGHT:    height_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lspc_front #(
		.PIXELS_PER_LINE(PIXELS_PER_LINE),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.samples          (samples),
		.samples_per_pixel(spp_q),
		.job_valid        (fq_valid),
		.job_data         (fq_data),
		.job_ready        (fq_ready)
	);

	lspc_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_data (fq_data),
		.push_ready(fq_ready),
		.pop_valid (qb_valid),
		.pop_data  (qb_data),
		.pop_ready (qb_ready)
	);

	lspc_back #(
		.PIXELS_PER_LINE(PIXELS_PER_LINE),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (qb_valid),
		.job_data      (qb_data),
		.job_ready     (qb_ready),
		.display_height(height_q),
		.pixels        (pixels)
	);

endmodule

// File: rtl/core/lspc_front.sv
module lspc_front import lspc_pkg::*; #(
	parameter int PIXELS_PER_LINE = DEF_PIXELS_PER_LINE,
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	localparam int SUM_W = SAMPLE_BITS + CFG_W,
	localparam int POS_W = $clog2(PIXELS_PER_LINE),
	localparam int JOB_W = SUM_W + CFG_W + POS_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	lspc_sample_if.sink      samples,
	input  logic [CFG_W-1:0] samples_per_pixel,
	output logic             job_valid,
	output logic [JOB_W-1:0] job_data,
	input  logic             job_ready
);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CFG_W-1:0] spp;
		logic [POS_W-1:0] pos;
		logic             last;
	} job_t;

	logic [SUM_W-1:0] sum_q;
	logic [CFG_W-1:0] cnt_q;
	logic [POS_W-1:0] pos_q;

	logic [SUM_W-1:0] base_sum, new_sum;
	logic [CFG_W-1:0] base_cnt, new_cnt, spp_eff;
	logic [POS_W-1:0] base_pos;
	logic             complete, last, accept;
	job_t             job;

	always_comb begin
		base_sum = samples.frame_start ? '0 : sum_q;
		base_cnt = samples.frame_start ? '0 : cnt_q;
		base_pos = samples.frame_start ? '0 : pos_q;
		new_sum  = base_sum + SUM_W'(samples.adc_sample);
		new_cnt  = base_cnt + CFG_W'(1);
		spp_eff  = (samples_per_pixel == '0) ? CFG_W'(1) : samples_per_pixel;
		complete = new_cnt >= spp_eff;
		last     = base_pos == POS_W'(PIXELS_PER_LINE - 1);
		job.sum  = new_sum;
		job.spp  = spp_eff;
		job.pos  = base_pos;
		job.last = last;
	end

	assign samples.ready = job_ready;
	assign accept        = samples.valid && job_ready;
	assign job_valid     = samples.valid && complete;
	assign job_data      = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (complete) begin
				sum_q <= '0;
				cnt_q <= '0;
				pos_q <= last ? '0 : base_pos + POS_W'(1);
			end else begin
				sum_q <= new_sum;
				cnt_q <= new_cnt;
				pos_q <= base_pos;
			end
		end
	end

endmodule

// File: rtl/core/lspc_queue.sv
module lspc_queue import lspc_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/lspc_back.sv
module lspc_back import lspc_pkg::*; #(
	parameter int PIXELS_PER_LINE = DEF_PIXELS_PER_LINE,
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	localparam int SUM_W = SAMPLE_BITS + CFG_W,
	localparam int POS_W = $clog2(PIXELS_PER_LINE),
	localparam int JOB_W = SUM_W + CFG_W + POS_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  logic [JOB_W-1:0] job_data,
	output logic             job_ready,
	input  logic [CFG_W-1:0] display_height,
	lspc_pixel_if.source     pixels
);

	localparam int CNT_W  = $clog2(SUM_W);
	localparam int PROD_W = SAMPLE_BITS + CFG_W;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
	// floor(x/3) == (x*683) >> 11 for every three-tap sum up to 3*255
	localparam logic [9:0] THIRD_MUL = 10'd683;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CFG_W-1:0] spp;
		logic [POS_W-1:0] pos;
		logic             last;
	} job_t;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_DIV       = 7'b0000010,
		ST_MUL       = 7'b0000100,
		ST_SCALE     = 7'b0001000,
		ST_SMOOTH    = 7'b0010000,
		ST_EMIT_PREV = 7'b0100000,
		ST_EMIT_LAST = 7'b1000000
	} state_t;

	state_t                state_q;
	job_t                  job;
	logic [SUM_W-1:0]      quo_q;
	logic [CFG_W-1:0]      rem_q, spp_q;
	logic [CNT_W-1:0]      step_q;
	logic [POS_W-1:0]      pos_q;
	logic                  last_q;
	logic [PROD_W-1:0]     prod_q;
	logic [VALUE_W-1:0]    scaled_q, pending_q, left_q, smooth_q;
	logic                  out_valid_q;
	logic [INDEX_W-1:0]    out_index_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_last_q;

	logic [CFG_W:0]           trial;
	logic                     trial_ge;
	logic [SAMPLE_BITS-1:0]   avg;
	logic [VALUE_W-1:0]       q0, qs, scaled;
	logic [SAMPLE_BITS:0]     resid;
	logic [9:0]               tap_sum;
	logic [19:0]              tap_prod;
	logic [VALUE_W-1:0]       smooth;
	logic                     out_free;

	assign job = job_t'(job_data);

	always_comb begin
		// restoring divider step: one quotient bit per cycle
		trial    = {rem_q, quo_q[SUM_W-1]};
		trial_ge = trial >= {1'b0, spp_q};
		avg      = (quo_q > SUM_W'(FULL_SCALE)) ? FULL_SCALE : quo_q[SAMPLE_BITS-1:0];

		// divide by 2^n-1: quotient from the high part, one correction
		q0    = prod_q[PROD_W-1:SAMPLE_BITS];
		resid = {1'b0, prod_q[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(q0);
		qs    = q0 + VALUE_W'(resid >= {1'b0, FULL_SCALE});
		if (display_height == '0) begin
			scaled = '0;
		end else if (qs >= display_height) begin
			scaled = display_height - VALUE_W'(1);
		end else begin
			scaled = qs;
		end

		tap_sum  = 10'(left_q) + 10'(pending_q) + 10'(scaled_q);
		tap_prod = 20'(tap_sum) * 20'(THIRD_MUL);
		smooth   = (pos_q == POS_W'(1)) ? pending_q : tap_prod[18:11];
	end

	assign out_free      = !out_valid_q || pixels.ready;
	assign job_ready     = state_q == ST_IDLE;
	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_index = out_index_q;
	assign pixels.pixel_value = out_value_q;
	assign pixels.last_pixel  = out_last_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q  <= job.sum;
				spp_q  <= job.spp;
				pos_q  <= job.pos;
				last_q <= job.last;
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= trial_ge ? CFG_W'(trial - {1'b0, spp_q}) : trial[CFG_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], trial_ge};
			end
			ST_MUL: begin
				prod_q <= PROD_W'(avg) * PROD_W'(display_height);
			end
			ST_SCALE: begin
				scaled_q <= scaled;
			end
			ST_SMOOTH: begin
				smooth_q  <= smooth;
				left_q    <= smooth;
				pending_q <= scaled_q;
			end
			default: begin
			end
		endcase
		if (out_free) begin
			if (state_q == ST_EMIT_PREV) begin
				out_index_q <= INDEX_W'(pos_q - POS_W'(1));
				out_value_q <= smooth_q;
				out_last_q  <= 1'b0;
			end else if (state_q == ST_EMIT_LAST) begin
				out_index_q <= INDEX_W'(pos_q);
				out_value_q <= scaled_q;
				out_last_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= (state_q == ST_EMIT_PREV) || (state_q == ST_EMIT_LAST);
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + CNT_W'(1);
					if (step_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_SMOOTH;
				end
				ST_SMOOTH: begin
					if (pos_q != '0) begin
						state_q <= ST_EMIT_PREV;
					end else if (last_q) begin
						state_q <= ST_EMIT_LAST;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_PREV: begin
					if (out_free) begin
						state_q <= last_q ? ST_EMIT_LAST : ST_IDLE;
					end
				end
				ST_EMIT_LAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
